// ----- rtl/core/fqpr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fqpr_pkg: shared definitions for the prefix-reversing FIFO queue
// Depth, derived widths, command and status codes, the result record and
// the ring-position helper used by the sequencer.
// ----------------------------------------------------------------------------
package fqpr_pkg;

  // Queue depth and the widths that follow from it.
  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  // Width of the input count field and the width used to compare it.
  localparam int KW    = 5;
  localparam int CMPW  = (CW > KW) ? CW : KW;
  localparam int DW    = 32;

  // Command codes.
  localparam logic [2:0] CMD_ENQ  = 3'd0;
  localparam logic [2:0] CMD_DEQ  = 3'd1;
  localparam logic [2:0] CMD_PEEK = 3'd2;
  localparam logic [2:0] CMD_REV  = 3'd3;
  localparam logic [2:0] CMD_LIST = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADCOUNT = 2'd3;

  // One result record handed from the sequencer to the output register.
  typedef struct packed {
    logic [1:0]    status;
    logic [DW-1:0] data;
    logic          last;
  } res_t;

  // Ring position of an offset from a base slot; the sum stays below
  // twice the depth, so one compare and subtract wraps it.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fqpr_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fqpr_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module fqpr_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/core/fqpr_obuf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fqpr_obuf: result output register
// Holds one result for the downstream side and tells the sequencer when a
// new result may be loaded.
// ----------------------------------------------------------------------------
module fqpr_obuf
  import fqpr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic emit_valid,
  input  wire res_t emit_res,
  output logic      can_emit,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      out_res
);

  logic valid_r, valid_nxt;
  res_t res_r;

  // The register is free when empty or when its result leaves this cycle.
  assign can_emit = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (emit_valid) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (emit_valid) begin
      res_r <= emit_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

// ----- rtl/core/fqpr_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fqpr_seq: command sequencer
// Keeps the head slot and occupancy, decodes each command and walks the
// entry memory for dequeue, peek, reverse and list.
// ----------------------------------------------------------------------------
module fqpr_seq
  import fqpr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           in_command,
  input  wire logic [DW-1:0]        in_value,
  input  wire logic [KW-1:0]        in_count,
  output logic                      ram_we,
  output logic      [AW-1:0]        ram_waddr,
  output logic      [DW-1:0]        ram_wdata,
  output logic                      ram_re,
  output logic      [AW-1:0]        ram_raddr,
  input  wire logic [DW-1:0]        ram_rdata,
  input  wire logic                 can_emit,
  output logic                      emit_valid,
  output res_t                      emit_res
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_RDWAIT = 4'd2;
  localparam logic [3:0] S_RA     = 4'd3;
  localparam logic [3:0] S_RB     = 4'd4;
  localparam logic [3:0] S_WA     = 4'd5;
  localparam logic [3:0] S_WB     = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;
  localparam logic [3:0] S_LRD    = 4'd8;
  localparam logic [3:0] S_LOUT   = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [2:0]    cmd_r;
  logic [DW-1:0] val_r;
  logic [KW-1:0] cnt_r;
  logic [DW-1:0] tmp_r, tmp_nxt;

  logic          accept;
  logic          is_empty;
  logic          is_full;
  logic          bad_count;
  logic          last_pair;
  logic          last_elem;
  logic [CMPW-1:0] off_b_w;
  logic [AW-1:0] pos_a;
  logic [AW-1:0] pos_b;
  logic [AW-1:0] pos_tail;
  logic [AW-1:0] head_inc;

  // Input handshake: a new transaction is taken only in the idle state.
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Status conditions and ring positions.
  assign is_empty  = (occ_r == '0);
  assign is_full   = (occ_r == CW'(DEPTH));
  assign bad_count = (cnt_r == '0) || (CMPW'(cnt_r) > CMPW'(occ_r));
  assign last_pair = ((CMPW'(idx_r) + CMPW'(1)) == CMPW'(cnt_r >> 1));
  assign last_elem = ((idx_r + CW'(1)) == occ_r);
  assign off_b_w   = CMPW'(cnt_r) - CMPW'(1) - CMPW'(idx_r);
  assign pos_a     = ring_add(head_r, idx_r);
  assign pos_b     = ring_add(head_r, off_b_w[CW-1:0]);
  assign pos_tail  = ring_add(head_r, occ_r);
  assign head_inc  = ring_add(head_r, CW'(1));

  // Next-state and memory control.
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    tmp_nxt    = tmp_r;
    ram_we     = 1'b0;
    ram_waddr  = pos_a;
    ram_wdata  = val_r;
    ram_re     = 1'b0;
    ram_raddr  = pos_a;
    emit_valid = 1'b0;
    emit_res   = '{status: ST_OK, data: '0, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        idx_nxt = '0;
        unique case (cmd_r)
          CMD_ENQ: begin
            if (can_emit) begin
              emit_valid = 1'b1;
              state_nxt  = S_IDLE;
              if (is_full) begin
                emit_res.status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pos_tail;
                ram_wdata = val_r;
                occ_nxt   = occ_r + CW'(1);
              end
            end
          end
          CMD_DEQ, CMD_PEEK: begin
            if (is_empty) begin
              if (can_emit) begin
                emit_valid      = 1'b1;
                emit_res.status = ST_EMPTY;
                state_nxt       = S_IDLE;
              end
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_r;
              state_nxt = S_RDWAIT;
            end
          end
          CMD_REV: begin
            if (is_empty || bad_count) begin
              if (can_emit) begin
                emit_valid      = 1'b1;
                emit_res.status = is_empty ? ST_EMPTY : ST_BADCOUNT;
                state_nxt       = S_IDLE;
              end
            end else if (cnt_r == KW'(1)) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_RA;
            end
          end
          CMD_LIST: begin
            if (is_empty) begin
              if (can_emit) begin
                emit_valid      = 1'b1;
                emit_res.status = ST_EMPTY;
                state_nxt       = S_IDLE;
              end
            end else begin
              state_nxt = S_LRD;
            end
          end
          default: begin
            if (can_emit) begin
              emit_valid = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
        endcase
      end

      // Head word is in the read register; dequeue also advances the head.
      S_RDWAIT: begin
        if (can_emit) begin
          emit_valid    = 1'b1;
          emit_res.data = ram_rdata;
          state_nxt     = S_IDLE;
          if (cmd_r == CMD_DEQ) begin
            head_nxt = head_inc;
            occ_nxt  = occ_r - CW'(1);
          end
        end
      end

      // Swap of one pair: read both ends, then write them back crossed.
      S_RA: begin
        ram_re    = 1'b1;
        ram_raddr = pos_a;
        state_nxt = S_RB;
      end
      S_RB: begin
        ram_re    = 1'b1;
        ram_raddr = pos_b;
        tmp_nxt   = ram_rdata;
        state_nxt = S_WA;
      end
      S_WA: begin
        ram_we    = 1'b1;
        ram_waddr = pos_a;
        ram_wdata = ram_rdata;
        state_nxt = S_WB;
      end
      S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = pos_b;
        ram_wdata = tmp_r;
        if (last_pair) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_RA;
        end
      end
      S_DONE: begin
        if (can_emit) begin
          emit_valid = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      // List walk: one read, then one result per entry.
      S_LRD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_a;
        state_nxt = S_LOUT;
      end
      S_LOUT: begin
        if (can_emit) begin
          emit_valid    = 1'b1;
          emit_res.data = ram_rdata;
          emit_res.last = last_elem;
          if (last_elem) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_LRD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // Captured transaction fields and walk registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      val_r <= in_value;
      cnt_r <= in_count;
    end
    idx_r <= idx_nxt;
    tmp_r <= tmp_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/fifo_queue_with_prefix_reverse.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_prefix_reverse: bounded FIFO with in-place prefix reverse
// Ring-buffer queue of signed 32-bit words with enqueue, dequeue, peek,
// reverse-first-k and list commands.
// ----------------------------------------------------------------------------
// One command is taken at a time; in_stall is high from acceptance until the
// command's last result has been loaded into the output register. A list
// walk makes one memory read and one result per entry, and a reverse of k
// entries swaps floor(k/2) pairs; each swapped pair costs two reads and two
// writes on the single read and single write port of the entry memory. The
// entry memory needs no clearing after reset; it is usable as soon as reset
// is released.
module fifo_queue_with_prefix_reverse
  import fqpr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_command,
  input  wire logic signed [31:0] in_value,
  input  wire logic [4:0]         in_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_data,
  output logic                    out_last
);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;
  logic          can_emit;
  logic          emit_valid;
  res_t          emit_res;
  res_t          out_res;

  // Command sequencer.
  fqpr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_value   (in_value),
    .in_count   (in_count),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .can_emit   (can_emit),
    .emit_valid (emit_valid),
    .emit_res   (emit_res)
  );

  // Entry storage.
  fqpr_ram #(
    .W (DW),
    .D (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register.
  fqpr_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit_valid (emit_valid),
    .emit_res   (emit_res),
    .can_emit   (can_emit),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_status = out_res.status;
  assign out_data   = out_res.data;
  assign out_last   = out_res.last;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the prefix-reversing FIFO queue
// A short directed table covers the empty, full, bad-count and unused
// command cases, then a few hundred random commands drift the queue between
// empty and full. A shadow queue predicts every result, and a scoreboard
// compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import fqpr_pkg::*;

  // Command codes the block treats as no-ops.
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 375;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 80;

  // One row of the directed table; typed rows carry their own expected result.
  typedef struct {
    logic [2:0]    cmd;
    logic [DW-1:0] val;
    logic [4:0]    cnt;
    int            reps;
    bit            typed;
    logic [1:0]    t_status;
    logic [DW-1:0] t_data;
  } stim_row_t;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_valid   = 1'b0;
  logic          in_stall;
  logic [2:0]    in_command = '0;
  logic [DW-1:0] in_value   = '0;
  logic [4:0]    in_count   = '0;
  logic          out_valid;
  logic          out_stall  = 1'b0;
  logic [1:0]    out_status;
  logic [DW-1:0] out_data;
  logic          out_last;

  // Shadow copy of the queue and the results it predicts.
  logic [DW-1:0] shadow_mem [DEPTH];
  int unsigned   shadow_head = 0;
  int unsigned   shadow_fill = 0;
  res_t          step_results[$];
  res_t          expected_results[$];
  stim_row_t     dir_table[$];

  // Run bookkeeping.
  int          errors         = 0;
  int          items_sent     = 0;
  int          results_seen   = 0;
  int          max_fill       = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  int          idle_count     = 0;
  int          burst_left     = 0;
  bit          sender_idles   = 1'b1;
  res_t        head_expect;

  // Receiver stall pattern state.
  logic [15:0] stall_pattern  = '0;
  int          stall_hold     = 0;
  int unsigned stall_phase    = 0;

  always #5 clk = ~clk;

  fifo_queue_with_prefix_reverse DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_value   (in_value),
    .in_count   (in_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last)
  );

  // Ring slot of an offset from the shadow head.
  function automatic int unsigned shadow_slot(input int unsigned off);
    return (shadow_head + off) % DEPTH;
  endfunction

  function automatic void add_result(input logic [1:0] st, input logic [DW-1:0] d,
                                     input logic l);
    res_t r;
    r.status = st;
    r.data   = d;
    r.last   = l;
    step_results.push_back(r);
  endfunction

  // Apply one command to the shadow queue and collect the results it causes.
  task automatic queue_model_step(input logic [2:0] cmd, input logic [DW-1:0] val,
                                  input logic [4:0] cnt);
    int unsigned   a;
    int unsigned   b;
    logic [DW-1:0] tmp;
    step_results.delete();
    case (cmd)
      CMD_ENQ: begin
        if (shadow_fill >= DEPTH) begin
          add_result(ST_FULL, '0, 1'b1);
        end else begin
          shadow_mem[shadow_slot(shadow_fill)] = val;
          shadow_fill++;
          add_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (shadow_fill == 0) begin
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          add_result(ST_OK, shadow_mem[shadow_slot(0)], 1'b1);
          if (cmd == CMD_DEQ) begin
            shadow_head = shadow_slot(1);
            shadow_fill--;
          end
        end
      end
      CMD_REV: begin
        if (shadow_fill == 0) begin
          add_result(ST_EMPTY, '0, 1'b1);
        end else if (cnt == 0 || cnt > shadow_fill) begin
          add_result(ST_BADCOUNT, '0, 1'b1);
        end else begin
          // Swap pairs from both ends of the prefix; later entries stay put.
          for (int unsigned i = 0; i < cnt / 2; i++) begin
            a = shadow_slot(i);
            b = shadow_slot(cnt - 1 - i);
            tmp = shadow_mem[a];
            shadow_mem[a] = shadow_mem[b];
            shadow_mem[b] = tmp;
          end
          add_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_LIST: begin
        if (shadow_fill == 0) begin
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < shadow_fill; i++) begin
            add_result(ST_OK, shadow_mem[shadow_slot(i)], (i + 1 == shadow_fill));
          end
        end
      end
      default: begin
        add_result(ST_OK, '0, 1'b1);
      end
    endcase
    if (shadow_fill > max_fill) max_fill = shadow_fill;
  endtask

  // Present one transaction at a falling edge and hold it until accepted.
  task automatic send_item(input logic [2:0] cmd, input logic [DW-1:0] val,
                           input logic [4:0] cnt, input bit typed,
                           input logic [1:0] t_status, input logic [DW-1:0] t_data);
    int   gap;
    res_t r;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_idles ? $urandom_range(1, 6) : 0;
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command <= cmd;
    in_value   <= val;
    in_count   <= cnt;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    queue_model_step(cmd, val, cnt);
    if (typed) begin
      r.status = t_status;
      r.data   = t_data;
      r.last   = 1'b1;
      expected_results.push_back(r);
    end else begin
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
    end
    items_sent++;
    @(negedge clk);
  endtask

  function automatic void add_row(input logic [2:0] c, input logic [DW-1:0] v,
                                  input logic [4:0] n, input int reps, input bit typed,
                                  input logic [1:0] st, input logic [DW-1:0] d);
    stim_row_t r;
    r.cmd = c;
    r.val = v;
    r.cnt = n;
    r.reps = reps;
    r.typed = typed;
    r.t_status = st;
    r.t_data = d;
    dir_table.push_back(r);
  endfunction

  // Receiver stalls follow a rotating 16-bit pattern, redrawn now and then.
  // Bit zero is always clear, so no stall lasts through a whole pass of the pattern.
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = '0;
        1:       stall_pattern = 16'($urandom & $urandom);
        2:       stall_pattern = 16'($urandom);
        default: stall_pattern = 16'($urandom | $urandom);
      endcase
      stall_pattern[0] = 1'b0;
      stall_hold = $urandom_range(40, 250);
    end
    stall_hold--;
    out_stall <= stall_pattern[stall_phase];
    stall_phase = (stall_phase + 1) % 16;
  end

  // Scoreboard: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d, data %0d, last %0d",
               out_status, $signed(out_data), out_last);
        errors++;
      end else begin
        head_expect = expected_results.pop_front();
        if (out_status !== head_expect.status) begin
          $error("status mismatch: expected %0d, actual %0d", head_expect.status, out_status);
          errors++;
        end
        if (out_data !== head_expect.data) begin
          $error("data mismatch: expected %0d, actual %0d",
                 $signed(head_expect.data), $signed(out_data));
          errors++;
        end
        if (out_last !== head_expect.last) begin
          $error("last mismatch: expected %0d, actual %0d", head_expect.last, out_last);
          errors++;
        end
        results_seen++;
        status_seen[out_status]++;
      end
    end
  end

  // Watchdog on cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin : stimulus
    logic [2:0]    cmd;
    logic [DW-1:0] val;
    logic [4:0]    cnt;
    int            real_items;
    int            fill_mode;
    int            enq_pct;
    int            deq_pct;
    int            pick;

    foreach (shadow_mem[i]) shadow_mem[i] = '0;

    // Directed table: empty queue, field extremes, full queue, bad counts.
    add_row(CMD_DEQ,     32'h0,        5'd0,  1, 1'b1, ST_EMPTY,    '0);
    add_row(CMD_PEEK,    32'h0,        5'd0,  1, 1'b1, ST_EMPTY,    '0);
    add_row(CMD_REV,     32'h0,        5'd31, 1, 1'b1, ST_EMPTY,    '0);
    add_row(CMD_LIST,    32'h0,        5'd0,  1, 1'b1, ST_EMPTY,    '0);
    add_row(CMD_ENQ,     32'h80000000, 5'd0,  1, 1'b1, ST_OK,       '0);
    add_row(CMD_PEEK,    32'h0,        5'd0,  1, 1'b1, ST_OK,       32'h80000000);
    add_row(CMD_ENQ,     32'h7FFFFFFF, 5'd0,  1, 1'b1, ST_OK,       '0);
    add_row(CMD_REV,     32'h0,        5'd0,  1, 1'b1, ST_BADCOUNT, '0);
    add_row(CMD_REV,     32'h0,        5'd3,  1, 1'b1, ST_BADCOUNT, '0);
    add_row(CMD_REV,     32'h0,        5'd2,  1, 1'b1, ST_OK,       '0);
    add_row(CMD_LIST,    32'h0,        5'd0,  1, 1'b0, ST_OK,       '0);
    add_row(CMD_DEQ,     32'h0,        5'd0,  1, 1'b0, ST_OK,       '0);
    add_row(CMD_SPARE_5, 32'hFFFFFFFF, 5'd31, 1, 1'b1, ST_OK,       '0);
    add_row(CMD_SPARE_6, 32'h0,        5'd0,  1, 1'b1, ST_OK,       '0);
    add_row(CMD_SPARE_7, 32'hFFFFFFFF, 5'd31, 1, 1'b1, ST_OK,       '0);
    add_row(CMD_ENQ,     32'h00001000, 5'd0,  DEPTH - 1, 1'b1, ST_OK, '0);
    add_row(CMD_ENQ,     32'h12345678, 5'd0,  1, 1'b1, ST_FULL,     '0);
    add_row(CMD_REV,     32'h0,        5'(DEPTH),     1, 1'b1, ST_OK,       '0);
    add_row(CMD_REV,     32'h0,        5'(DEPTH + 1), 1, 1'b1, ST_BADCOUNT, '0);
    add_row(CMD_LIST,    32'h0,        5'd0,  1, 1'b0, ST_OK,       '0);
    add_row(CMD_DEQ,     32'h0,        5'd0,  1, 1'b0, ST_OK,       '0);
    add_row(CMD_ENQ,     32'hFFFFFFFF, 5'd0,  1, 1'b1, ST_OK,       '0);
    add_row(CMD_REV,     32'h0,        5'd9,  1, 1'b0, ST_OK,       '0);
    add_row(CMD_LIST,    32'h0,        5'd0,  1, 1'b0, ST_OK,       '0);

    // Synchronous reset, released at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part; repeated enqueues store consecutive values.
    foreach (dir_table[r]) begin
      for (int k = 0; k < dir_table[r].reps; k++) begin
        send_item(dir_table[r].cmd, dir_table[r].val + k, dir_table[r].cnt,
                  dir_table[r].typed, dir_table[r].t_status, dir_table[r].t_data);
      end
    end

    // Random part: the mix drifts between balanced, filling and draining so the
    // queue visits both empty and full with wrapped head positions.
    real_items = 0;
    fill_mode = 0;
    while (real_items < RANDOM_ITEMS) begin
      if (real_items % 50 == 0) begin
        fill_mode = $urandom_range(0, 2);
        sender_idles = ($urandom_range(0, 3) != 0);
      end
      enq_pct = (fill_mode == 1) ? 60 : (fill_mode == 2) ? 15 : 35;
      deq_pct = (fill_mode == 2) ? 45 : 25;
      pick = $urandom_range(0, 99);
      if (pick < enq_pct) begin
        cmd = CMD_ENQ;
      end else if (pick < enq_pct + deq_pct) begin
        cmd = CMD_DEQ;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15)      cmd = CMD_PEEK;
        else if (pick < 60) cmd = CMD_REV;
        else if (pick < 93) cmd = CMD_LIST;
        else                cmd = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
      end

      case ($urandom_range(0, 9))
        0:       val = 32'h80000000;
        1:       val = 32'h7FFFFFFF;
        2:       val = 32'hFFFFFFFF;
        3:       val = 32'($urandom_range(0, 15));
        default: val = $urandom;
      endcase

      // Reverse counts are mostly in range, with zero and overshoot mixed in.
      pick = $urandom_range(0, 9);
      if (cmd != CMD_REV)                  cnt = 5'($urandom_range(0, 31));
      else if (shadow_fill > 0 && pick < 7) cnt = 5'($urandom_range(1, shadow_fill));
      else if (pick == 7)                  cnt = 5'd0;
      else if (pick == 8)                  cnt = 5'($urandom_range(shadow_fill + 1, 31));
      else                                 cnt = 5'($urandom_range(0, 31));

      send_item(cmd, val, cnt, 1'b0, ST_OK, '0);
      if (cmd <= CMD_LIST) real_items++;
    end
    in_valid <= 1'b0;

    // Wait for every outstanding result, then watch for strays.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run summary: %0d commands sent, %0d results checked, peak occupancy %0d.",
             items_sent, results_seen, max_fill);
    $display("Result statuses: ok %0d, empty %0d, full %0d, bad count %0d.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_BADCOUNT]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- fifo_queue_with_prefix_reverse.f -----
rtl/core/fqpr_pkg.sv
rtl/core/fqpr_ram.sv
rtl/core/fqpr_obuf.sv
rtl/core/fqpr_seq.sv
rtl/core/fifo_queue_with_prefix_reverse.sv
tb/tb_top.sv
